FILE: src/assert_macros.svh
// assertion macros for the top rtl file of the payload expand/split block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge of clk, off while rst is high
`define TPES_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every rising edge of clk, reset included
`define TPES_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/tpes_pkg.sv
// shared constants, register codes and types of the payload expand/split block
package tpes_pkg;

  localparam int MAX_SIGNALS   = 8;
  localparam int PAYLOAD_BYTES = 8;
  localparam int DATA_W        = 64;
  localparam int WIDTH_BITS    = 7;
  localparam int WIDTHS_W      = MAX_SIGNALS * WIDTH_BITS;
  localparam int COUNT_W       = 4;
  localparam int INDEX_W       = 3;
  localparam int START_W       = 10;

  // configuration register indexes
  typedef logic [1:0] cfg_addr_t;
  localparam cfg_addr_t CFG_DECODE_SEED   = 2'd0;
  localparam cfg_addr_t CFG_SIGNAL_COUNT  = 2'd1;
  localparam cfg_addr_t CFG_SIGNAL_WIDTHS = 2'd2;

  // reset values of the configuration registers
  localparam logic [DATA_W-1:0]   SEED_RESET   = '0;
  localparam logic [COUNT_W-1:0]  COUNT_RESET  = 4'd1;
  localparam logic [WIDTHS_W-1:0] WIDTHS_RESET = 56'd64;

  typedef struct packed {
    logic [DATA_W-1:0]   decode_seed;
    logic [COUNT_W-1:0]  signal_count;
    logic [WIDTHS_W-1:0] signal_widths;
  } tpes_cfg_t;

endpackage

FILE: src/tpes_expand.sv
// rebuilds the 64-bit payload from the byte enables, packed bytes and seed
module tpes_expand import tpes_pkg::*; (
  input  tpes_cfg_t                 cfg,
  input  logic [PAYLOAD_BYTES-1:0]  byte_enables,
  input  logic [DATA_W-1:0]         compressed_data,
  output logic [DATA_W-1:0]         payload,
  output logic [COUNT_W-1:0]        consumed
);

  // each enabled position takes the byte at the running count of earlier enables
  always_comb begin
    logic [COUNT_W-1:0] pos;
    pos = '0;
    payload = '0;
    for (int i = 0; i < PAYLOAD_BYTES; i++) begin
      if (byte_enables[i]) begin
        payload[i*8 +: 8] = compressed_data[pos[2:0]*8 +: 8];
        pos = pos + 4'd1;
      end else begin
        payload[i*8 +: 8] = cfg.decode_seed[i*8 +: 8];
      end
    end
    consumed = pos;
  end

endmodule

FILE: src/tpes_split.sv
// holds one rebuilt payload and issues its signal results into an output register
module tpes_split import tpes_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  tpes_cfg_t           cfg,
  input  logic                load,
  input  logic [DATA_W-1:0]   load_payload,
  input  logic [COUNT_W-1:0]  load_consumed,
  output logic                free,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [INDEX_W-1:0]  signal_index,
  output logic [DATA_W-1:0]   signal_value,
  output logic [DATA_W-1:0]   decoded_payload,
  output logic [COUNT_W-1:0]  payload_bytes,
  output logic                last_signal
);

  // packet holding stage
  logic                held;
  logic [DATA_W-1:0]   payload;
  logic [COUNT_W-1:0]  consumed;
  logic [INDEX_W-1:0]  sig;
  logic [START_W-1:0]  start;

  logic [COUNT_W-1:0]    count_eff;
  logic [WIDTH_BITS-1:0] width;
  logic [START_W-1:0]    end_pos;
  logic                  in_range;
  logic [DATA_W-1:0]     mask;
  logic [DATA_W-1:0]     value;
  logic                  is_last;
  logic                  fire;
  logic                  done;

  // clamp the signal count to the number of width fields
  assign count_eff = (cfg.signal_count > COUNT_W'(MAX_SIGNALS)) ?
                     COUNT_W'(MAX_SIGNALS) : cfg.signal_count;

  // current signal's width, range check and masked extract
  assign width    = cfg.signal_widths[sig*WIDTH_BITS +: WIDTH_BITS];
  assign end_pos  = start + START_W'(width);
  assign in_range = (width != '0) && (end_pos <= START_W'(DATA_W));
  assign mask     = {DATA_W{1'b1}} >> (7'(DATA_W) - width);
  assign value    = in_range ? ((payload >> start[5:0]) & mask) : '0;
  assign is_last  = ({1'b0, sig} + 4'd1) == count_eff;

  // a result moves when the output register is empty or being drained
  assign fire = held && (count_eff != '0) && (!out_valid || out_ready);
  assign done = (count_eff == '0) || (fire && is_last);
  assign free = !held || done;

  // holding stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (load) begin
      held <= 1'b1;
    end else if (done) begin
      held <= 1'b0;
    end
  end

  // holding stage payload and signal walk
  always_ff @(posedge clk) begin
    if (load) begin
      payload  <= load_payload;
      consumed <= load_consumed;
      sig      <= '0;
      start    <= '0;
    end else if (fire) begin
      sig   <= sig + 3'd1;
      start <= end_pos;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (fire) begin
      signal_index    <= sig;
      signal_value    <= value;
      decoded_payload <= payload;
      payload_bytes   <= consumed;
      last_signal     <= is_last;
    end
  end

endmodule

FILE: src/trace_payload_expand_split.sv
// top level of the trace payload expand/split block: config registers and wiring
// a packet is captured in the holding stage when accepted; each of its results then moves
// into the result register when that register is empty or being drained: one result per
// cycle while out_ready stays high, none for a count of zero; a new packet is taken as the
// last result moves out. the result register is the only limit besides the signal walk in tpes_split
// reset (rst, synchronous): seed 0, one signal of width 64, no packet or result held
module trace_payload_expand_split import tpes_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [PAYLOAD_BYTES-1:0]  byte_enables,
  input  logic [DATA_W-1:0]         compressed_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [INDEX_W-1:0]        signal_index,
  output logic [DATA_W-1:0]         signal_value,
  output logic [DATA_W-1:0]         decoded_payload,
  output logic [COUNT_W-1:0]        payload_bytes,
  output logic                      last_signal,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  cfg_addr_t                 cfg_index,
  input  logic [DATA_W-1:0]         cfg_data
);

`include "assert_macros.svh"

  tpes_cfg_t          cfg;
  logic [DATA_W-1:0]  exp_payload;
  logic [COUNT_W-1:0] exp_consumed;
  logic               split_free;
  logic               in_fire;

  assign cfg_ready = !rst;
  assign in_ready  = !rst && split_free;
  assign in_fire   = in_valid && in_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.decode_seed   <= SEED_RESET;
      cfg.signal_count  <= COUNT_RESET;
      cfg.signal_widths <= WIDTHS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DECODE_SEED:   cfg.decode_seed   <= cfg_data;
        CFG_SIGNAL_COUNT:  cfg.signal_count  <= cfg_data[COUNT_W-1:0];
        CFG_SIGNAL_WIDTHS: cfg.signal_widths <= cfg_data[WIDTHS_W-1:0];
        default: ;
      endcase
    end
  end

  // payload rebuild ahead of the holding stage
  tpes_expand u_expand (
    .cfg             (cfg),
    .byte_enables    (byte_enables),
    .compressed_data (compressed_data),
    .payload         (exp_payload),
    .consumed        (exp_consumed)
  );

  // signal split and result register
  tpes_split u_split (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .load            (in_fire),
    .load_payload    (exp_payload),
    .load_consumed   (exp_consumed),
    .free            (split_free),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .signal_index    (signal_index),
    .signal_value    (signal_value),
    .decoded_payload (decoded_payload),
    .payload_bytes   (payload_bytes),
    .last_signal     (last_signal)
  );

  // a taken non-final result is followed at once by the next signal of the packet
  `TPES_ASSERT(a_next_signal, out_valid && out_ready && !last_signal |=> out_valid && signal_index == $past(signal_index) + 3'd1, "next signal result missing or out of order")

  // after the final result of a packet, any next result starts a new packet
  `TPES_ASSERT(a_new_packet, out_valid && out_ready && last_signal |=> !out_valid || signal_index == '0, "new packet does not start at signal zero")

  // the consumed byte count never exceeds the payload size
  `TPES_ASSERT_ALWAYS(a_bytes_range, out_valid |-> payload_bytes <= 4'd8, "payload byte count out of range")

endmodule

FILE: bench/tb_trace_payload_expand_split.sv
// testbench for trace_payload_expand_split: directed table, random packets, signal predictor
module tb_trace_payload_expand_split;
  timeunit 1ns;
  timeprecision 1ps;
  import tpes_pkg::*;

  // index with no register behind it, written once
  localparam cfg_addr_t CFG_SPARE = 2'd3;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES = 200;
  localparam int RANDOM_PHASES = 9;
  localparam int ITEMS_PER_PHASE = 50;

  typedef enum int {RX_STEADY, RX_COIN, RX_THIRD, RX_SPARSE} rx_mode_t;

  typedef struct packed {
    logic [INDEX_W-1:0] index;
    logic [DATA_W-1:0]  value;
    logic [DATA_W-1:0]  payload;
    logic [COUNT_W-1:0] nbytes;
    logic               last;
  } signal_result_t;

  // one row of the directed table; settings apply before the item when set_cfg is high
  typedef struct {
    bit                  set_cfg;
    logic [DATA_W-1:0]   seed;
    logic [COUNT_W-1:0]  count;
    logic [WIDTHS_W-1:0] widths;
    logic [7:0]          en;
    logic [DATA_W-1:0]   data;
    bit                  typed;
    logic [DATA_W-1:0]   exp_payload;
    logic [COUNT_W-1:0]  exp_bytes;
  } packet_row_t;

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     in_valid;
  logic                     in_ready;
  logic [PAYLOAD_BYTES-1:0] byte_enables;
  logic [DATA_W-1:0]        compressed_data;
  logic                     out_valid;
  logic                     out_ready;
  logic [INDEX_W-1:0]       signal_index;
  logic [DATA_W-1:0]        signal_value;
  logic [DATA_W-1:0]        decoded_payload;
  logic [COUNT_W-1:0]       payload_bytes;
  logic                     last_signal;
  logic                     cfg_valid;
  logic                     cfg_ready;
  cfg_addr_t                cfg_index;
  logic [DATA_W-1:0]        cfg_data;

  // predictor copy of the registers
  logic [DATA_W-1:0]   seed_reg;
  logic [COUNT_W-1:0]  count_reg;
  logic [WIDTHS_W-1:0] widths_reg;

  signal_result_t pending_signals[$];
  packet_row_t    directed_rows[$];
  int             mismatch_count = 0;
  int             burst_left;
  bit             hold_req;

  trace_payload_expand_split i_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .byte_enables    (byte_enables),
    .compressed_data (compressed_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .signal_index    (signal_index),
    .signal_value    (signal_value),
    .decoded_payload (decoded_payload),
    .payload_bytes   (payload_bytes),
    .last_signal     (last_signal),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // append one expected result item at the tail of the queue
  task automatic queue_result(input signal_result_t res);
    pending_signals = {pending_signals, res};
  endtask

  // rebuild the payload from enables and packed bytes, then cut it into signals
  task automatic expand_and_split(input logic [7:0] en, input logic [DATA_W-1:0] data);
    logic [DATA_W-1:0] payload;
    logic [DATA_W-1:0] field;
    int taken;
    int start;
    int total;
    int w;
    taken = 0;
    start = 0;
    for (int i = 0; i < PAYLOAD_BYTES; i++) begin
      if (en[i]) begin
        payload[8*i +: 8] = data[8*taken +: 8];
        taken++;
      end else begin
        payload[8*i +: 8] = seed_reg[8*i +: 8];
      end
    end
    total = (count_reg > MAX_SIGNALS) ? MAX_SIGNALS : int'(count_reg);
    for (int k = 0; k < total; k++) begin
      w = int'(widths_reg[WIDTH_BITS*k +: WIDTH_BITS]);
      // zero width and ranges past bit 63 give 0; full width takes everything
      if (w == 0 || start + w > DATA_W) field = '0;
      else if (w == DATA_W) field = payload;
      else field = (payload >> start) & ((64'd1 << w) - 64'd1);
      queue_result('{index: INDEX_W'(k), value: field, payload: payload,
                     nbytes: COUNT_W'(taken), last: (k == total - 1)});
      start += w;
    end
  endtask

  // offer one item, hold it until taken, then maybe end the burst
  task automatic send_packet(input logic [7:0] en, input logic [DATA_W-1:0] data,
                             input bit typed, input logic [DATA_W-1:0] exp_payload,
                             input logic [COUNT_W-1:0] exp_bytes);
    in_valid = 1'b1;
    byte_enables = en;
    compressed_data = data;
    do @(posedge clk); while (!in_ready);
    if (typed) begin
      queue_result('{index: '0, value: exp_payload, payload: exp_payload,
                     nbytes: exp_bytes, last: 1'b1});
    end else begin
      expand_and_split(en, data);
    end
    @(negedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
  endtask

  // drain the block, including items that give no result
  task automatic settle_block();
    in_valid = 1'b0;
    while (pending_signals.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // one register write; the caller lowers cfg_valid after its last write
  task automatic write_register(input cfg_addr_t idx, input logic [DATA_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_DECODE_SEED:   seed_reg = data;
      CFG_SIGNAL_COUNT:  count_reg = data[COUNT_W-1:0];
      CFG_SIGNAL_WIDTHS: widths_reg = data[WIDTHS_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic configure(input logic [DATA_W-1:0] seed, input logic [COUNT_W-1:0] count,
                           input logic [WIDTHS_W-1:0] widths);
    settle_block();
    write_register(CFG_DECODE_SEED, seed);
    write_register(CFG_SIGNAL_COUNT, {{(DATA_W-COUNT_W){1'b0}}, count});
    write_register(CFG_SIGNAL_WIDTHS, {{(DATA_W-WIDTHS_W){1'b0}}, widths});
    cfg_valid = 1'b0;
  endtask

  function automatic void compare_field(input string name, input logic [DATA_W-1:0] exp_val,
                                        input logic [DATA_W-1:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_val, act_val);
      mismatch_count++;
    end
  endfunction

  // check every result item against the oldest expectation
  always @(posedge clk) begin : result_check
    signal_result_t exp_res;
    if (!rst && out_valid && out_ready) begin
      if (pending_signals.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual index %0d value %h",
                 $time, signal_index, signal_value);
        mismatch_count++;
      end else begin
        exp_res = pending_signals.pop_front();
        compare_field("signal_index", exp_res.index, signal_index);
        compare_field("signal_value", exp_res.value, signal_value);
        compare_field("decoded_payload", exp_res.payload, decoded_payload);
        compare_field("payload_bytes", exp_res.nbytes, payload_bytes);
        compare_field("last_signal", exp_res.last, last_signal);
      end
    end
  end

  // receiver stall pattern, with one long hold-off on request
  initial begin : receiver
    int cyc;
    rx_mode_t mode;
    cyc = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) @(negedge clk);
        hold_req = 1'b0;
      end
      mode = rx_mode_t'((cyc / 50) % 4);
      cyc++;
      case (mode)
        RX_STEADY: out_ready = 1'b1;
        RX_COIN:   out_ready = 1'($urandom_range(0, 1));
        RX_THIRD:  out_ready = (cyc % 3 == 0);
        RX_SPARSE: out_ready = ($urandom_range(0, 7) != 0);
        default:   out_ready = 1'b1;
      endcase
    end
  end

  // stimulus: directed table, then random settings and packets
  initial begin : stimulus
    logic [WIDTHS_W-1:0] widths;
    logic [COUNT_W-1:0] count;
    logic [7:0] en;
    int remaining;
    int w;
    int pick;
    rst = 1'b1;
    in_valid = 1'b0;
    byte_enables = '0;
    compressed_data = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_DECODE_SEED;
    cfg_data = '0;
    hold_req = 1'b0;
    burst_left = 1;
    seed_reg = SEED_RESET;
    count_reg = COUNT_RESET;
    widths_reg = WIDTHS_RESET;

    directed_rows = '{
      // reset settings: one full-width signal over the payload, seed 0
      '{0, 64'h0, 4'd0, 56'h0, 8'hFF, 64'h0123_4567_89AB_CDEF,
        1, 64'h0123_4567_89AB_CDEF, 4'd8},
      '{0, 64'h0, 4'd0, 56'h0, 8'h00, 64'hFFFF_FFFF_FFFF_FFFF, 1, 64'h0, 4'd0},
      // unused compressed bytes are ignored
      '{0, 64'h0, 4'd0, 56'h0, 8'h01, 64'hFFFF_FFFF_FFFF_FFAB, 1, 64'hAB, 4'd1},
      '{0, 64'h0, 4'd0, 56'h0, 8'h80, 64'h0000_0000_0000_005A,
        1, 64'h5A00_0000_0000_0000, 4'd1},
      '{0, 64'h0, 4'd0, 56'h0, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF,
        1, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8},
      '{0, 64'h0, 4'd0, 56'h0, 8'h55, 64'h0, 1, 64'h0, 4'd4},
      // eight byte-wide signals
      '{1, 64'hA5A5_A5A5_A5A5_A5A5, 4'd8, {8{7'd8}}, 8'hAA, 64'h1122_3344_5566_7788,
        0, 64'h0, 4'd0},
      '{0, 64'h0, 4'd0, 56'h0, 8'h0F, 64'hDEAD_BEEF_CAFE_F00D, 0, 64'h0, 4'd0},
      '{0, 64'h0, 4'd0, 56'h0, 8'hF0, 64'h0000_0000_8765_4321, 0, 64'h0, 4'd0},
      // zero width, full width at start 0, then a range past bit 63
      '{1, 64'hFEDC_BA98_7654_3210, 4'd4, {{5{7'd0}}, 7'd1, 7'd64, 7'd0}, 8'h3C,
        64'h0F1E_2D3C_4B5A_6978, 0, 64'h0, 4'd0},
      '{0, 64'h0, 4'd0, 56'h0, 8'h00, 64'h1234_5678_9ABC_DEF0, 0, 64'h0, 4'd0},
      // count above range, oversized first width
      '{1, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, {{7{7'd5}}, 7'd127}, 8'hC3,
        64'h0000_0000_0000_0000, 0, 64'h0, 4'd0},
      // count of zero: no results
      '{1, 64'h0, 4'd0, {8{7'd8}}, 8'hFF, 64'hCAFE_BABE_0BAD_F00D, 0, 64'h0, 4'd0},
      '{0, 64'h0, 4'd0, 56'h0, 8'h12, 64'h0000_0000_0000_BEEF, 0, 64'h0, 4'd0},
      // widths ending exactly at bit 63
      '{1, 64'h0, 4'd8, {7'd36, 7'd7, 7'd6, 7'd5, 7'd4, 7'd3, 7'd2, 7'd1}, 8'h81,
        64'h0000_0000_0000_C3A5, 0, 64'h0, 4'd0},
      '{0, 64'h0, 4'd0, 56'h0, 8'h7E, 64'h6655_4433_2211_0099, 0, 64'h0, 4'd0},
      '{1, 64'h0123_4567_89AB_CDEF, 4'd2, {{6{7'd0}}, 7'd63, 7'd1}, 8'h01,
        64'h0000_0000_0000_00FE, 0, 64'h0, 4'd0}
    };

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[r]) begin
      if (directed_rows[r].set_cfg) begin
        configure(directed_rows[r].seed, directed_rows[r].count, directed_rows[r].widths);
      end
      send_packet(directed_rows[r].en, directed_rows[r].data, directed_rows[r].typed,
                  directed_rows[r].exp_payload, directed_rows[r].exp_bytes);
    end

    // one write to the spare index, which has no register behind it
    settle_block();
    write_register(CFG_SPARE, {$urandom, $urandom});
    cfg_valid = 1'b0;

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      // random widths: fitting, in range, full 7-bit, or narrow
      pick = $urandom_range(0, 3);
      remaining = DATA_W;
      for (int k = 0; k < MAX_SIGNALS; k++) begin
        case (pick)
          0: begin
            w = $urandom_range(0, remaining);
            remaining -= w;
          end
          1: w = $urandom_range(0, 64);
          2: w = $urandom_range(0, 127);
          default: w = $urandom_range(1, 16);
        endcase
        widths[WIDTH_BITS*k +: WIDTH_BITS] = WIDTH_BITS'(w);
      end
      pick = $urandom_range(0, 9);
      if (pick < 8) count = COUNT_W'(pick + 1);
      else if (pick == 8) count = '0;
      else count = COUNT_W'($urandom_range(9, 15));
      if (phase == 0) count = COUNT_W'(MAX_SIGNALS);
      configure({$urandom, $urandom}, count, widths);
      // long receiver hold while every packet carries eight signals
      if (phase == 0) hold_req = 1'b1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        pick = $urandom_range(0, 9);
        if (pick == 0) en = 8'h00;
        else if (pick == 1) en = 8'hFF;
        else en = 8'($urandom);
        send_packet(en, {$urandom, $urandom}, 0, '0, '0);
      end
    end

    settle_block();
    if (mismatch_count == 0) begin
      $display("[trace_payload_expand_split] OK");
    end else begin
      $display("[trace_payload_expand_split] ERROR");
    end
    $finish;
  end

  // run limit
  initial begin : watchdog
    #2ms;
    $display("[trace_payload_expand_split] ERROR");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+src
src/tpes_pkg.sv
src/tpes_expand.sv
src/tpes_split.sv
src/trace_payload_expand_split.sv
bench/tb_trace_payload_expand_split.sv
